>>> hw/rtl/quadratic_root_solver_core_macros.svh
// Assertion macros shared by the quadratic root solver RTL.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define QRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QRS_ASSERT(lbl, clk, rst, prop, msg)
`define QRS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> hw/rtl/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
// No dependencies.
package qrs_pkg;
   localparam int SQRT_STEPS = 33;  // one result bit per stage
   localparam int DIV_STEPS  = 35;  // one quotient bit per stage
   localparam int RAD_W      = 34;  // |discriminant|
   localparam int ROOT_W     = 34;  // Q.16 square root
   localparam int NEGB_W     = 33;  // -b in Q.16
   localparam int DEN_W      = 17;  // |2a|
   localparam int MAG_W      = 35;  // numerator magnitude
   localparam int VAL_W      = 34;  // Q18.16 result

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_TWO     = 2'd1,
      KIND_DOUBLE  = 2'd2,
      KIND_COMPLEX = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic                      a_neg;
      logic [DEN_W-1:0]          den_abs;
      logic signed [NEGB_W-1:0]  negb;
   } sq_side_type;

   typedef struct packed {
      kind_type kind;
      logic     neg1;
      logic     neg2;
   } div_side_type;
endpackage

>>> hw/rtl/qrs_sqrt_pipe.sv
// Pipelined digit-by-digit square root, floor(sqrt(rad * 2^32)), one bit per stage.
// Depends on qrs_pkg.
module qrs_sqrt_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [qrs_pkg::RAD_W-1:0] in_rad,
   input  qrs_pkg::sq_side_type      in_side,
   output logic                      out_valid,
   output logic [qrs_pkg::ROOT_W-1:0] out_root,
   output qrs_pkg::sq_side_type      out_side
);
   import qrs_pkg::*;

   logic              valid_ff [SQRT_STEPS];
   logic [RAD_W-1:0]  rad_ff   [SQRT_STEPS];
   logic [35:0]       rem_ff   [SQRT_STEPS];
   logic [ROOT_W-1:0] root_ff  [SQRT_STEPS];
   sq_side_type       side_ff  [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic              valid_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [35:0]       rem_prev;
      logic [ROOT_W-1:0] root_prev;
      sq_side_type       side_prev;
      logic [37:0]       rem_sh;
      logic [37:0]       trial;
      logic [35:0]       rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rad_prev   = in_rad;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rad_prev   = rad_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_prev, rad_prev[RAD_W-1 -: 2]};
         trial  = {2'b00, root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = 36'(rem_sh - trial);
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[35:0];
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_prev;
         end
         if (advance) begin
            rad_ff[k]  <= {rad_prev[RAD_W-3:0], 2'b00};
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1];
   assign out_side  = side_ff[SQRT_STEPS-1];
endmodule

>>> hw/rtl/qrs_div_pipe.sv
// Pipelined restoring divider, two numerator lanes over one shared divisor.
// Depends on qrs_pkg.
module qrs_div_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [qrs_pkg::MAG_W-1:0] in_num1,
   input  logic [qrs_pkg::MAG_W-1:0] in_num2,
   input  logic [qrs_pkg::DEN_W-1:0] in_den,
   input  qrs_pkg::div_side_type     in_side,
   output logic                      out_valid,
   output logic [qrs_pkg::MAG_W-1:0] out_quo1,
   output logic [qrs_pkg::MAG_W-1:0] out_quo2,
   output qrs_pkg::div_side_type     out_side
);
   import qrs_pkg::*;

   logic             valid_ff [DIV_STEPS];
   logic [MAG_W-1:0] num1_ff  [DIV_STEPS];
   logic [MAG_W-1:0] num2_ff  [DIV_STEPS];
   logic [DEN_W-1:0] rem1_ff  [DIV_STEPS];
   logic [DEN_W-1:0] rem2_ff  [DIV_STEPS];
   logic [MAG_W-1:0] quo1_ff  [DIV_STEPS];
   logic [MAG_W-1:0] quo2_ff  [DIV_STEPS];
   logic [DEN_W-1:0] den_ff   [DIV_STEPS];
   div_side_type     side_ff  [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic             valid_prev;
      logic [MAG_W-1:0] num1_prev, num2_prev, quo1_prev, quo2_prev;
      logic [DEN_W-1:0] rem1_prev, rem2_prev, den_prev;
      div_side_type     side_prev;
      logic [DEN_W:0]   sh1, sh2;
      logic             take1, take2;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign num1_prev  = in_num1;
         assign num2_prev  = in_num2;
         assign rem1_prev  = '0;
         assign rem2_prev  = '0;
         assign quo1_prev  = '0;
         assign quo2_prev  = '0;
         assign den_prev   = in_den;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign num1_prev  = num1_ff[k-1];
         assign num2_prev  = num2_ff[k-1];
         assign rem1_prev  = rem1_ff[k-1];
         assign rem2_prev  = rem2_ff[k-1];
         assign quo1_prev  = quo1_ff[k-1];
         assign quo2_prev  = quo2_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      always_comb begin
         sh1   = {rem1_prev, num1_prev[MAG_W-1]};
         sh2   = {rem2_prev, num2_prev[MAG_W-1]};
         take1 = sh1 >= {1'b0, den_prev};
         take2 = sh2 >= {1'b0, den_prev};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_prev;
         end
         if (advance) begin
            num1_ff[k] <= {num1_prev[MAG_W-2:0], 1'b0};
            num2_ff[k] <= {num2_prev[MAG_W-2:0], 1'b0};
            rem1_ff[k] <= take1 ? DEN_W'(sh1 - {1'b0, den_prev}) : sh1[DEN_W-1:0];
            rem2_ff[k] <= take2 ? DEN_W'(sh2 - {1'b0, den_prev}) : sh2[DEN_W-1:0];
            quo1_ff[k] <= {quo1_prev[MAG_W-2:0], take1};
            quo2_ff[k] <= {quo2_prev[MAG_W-2:0], take2};
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_quo1  = quo1_ff[DIV_STEPS-1];
   assign out_quo2  = quo2_ff[DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];
endmodule

>>> hw/rtl/quadratic_root_solver_core.sv
// Quadratic root solver: roots of a*x^2 + b*x + c = 0 per request.
// Depends on qrs_pkg, qrs_sqrt_pipe, qrs_div_pipe and the assertion macro header.
//
// Usage:
//   A request carries three signed 16-bit coefficients on req_coef_a/b/c and
//   is taken at a clock edge where req_valid is high and req_stall is low.
//   Each request gives one result: rsp_root_kind and two signed Q18.16
//   values, taken at an edge where rsp_valid is high and rsp_stall is low.
//   Throughput is one request per cycle while not stalled. The accepting edge loads
//   the input register, and rsp_valid rises at the end of 73 register
//   stages: the input register, two stages for the products and the
//   discriminant, 33 square root stages (one root bit each), one numerator
//   stage, 35 divider stages (one quotient bit each) and the output register.
//   The whole pipeline moves as one: while a result waits under rsp_stall,
//   every stage holds and req_stall is raised, so nothing is lost or repeated.
//   A synchronous reset clears every valid bit; the pipeline is empty after.
`include "quadratic_root_solver_core_macros.svh"
module quadratic_root_solver_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [15:0]                req_coef_a,
   input  logic signed [15:0]                req_coef_b,
   input  logic signed [15:0]                req_coef_c,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_root_kind,
   output logic signed [qrs_pkg::VAL_W-1:0]  rsp_first_value,
   output logic signed [qrs_pkg::VAL_W-1:0]  rsp_second_value
);
   import qrs_pkg::*;

   logic advance;

   // Input stage.
   logic               s0_valid_ff;
   logic signed [15:0] s0_a_ff, s0_b_ff, s0_c_ff;
   // Product stage.
   logic               s1_valid_ff;
   logic signed [15:0] s1_a_ff, s1_b_ff;
   logic signed [31:0] s1_bb_ff, s1_ac_ff;
   // Discriminant stage.
   logic               s2_valid_ff;
   logic [RAD_W-1:0]   s2_rad_ff;
   sq_side_type        s2_side_ff;
   logic signed [34:0] disc;
   logic [15:0]        a_abs;
   logic signed [16:0] negb_int;
   sq_side_type        s2_side_in;
   logic [RAD_W-1:0]   s2_rad_in;
   // Square root output.
   logic               sq_valid;
   logic [ROOT_W-1:0]  sq_root;
   sq_side_type        sq_side;
   // Numerator stage.
   logic               nm_valid_ff;
   logic [MAG_W-1:0]   nm_mag1_ff, nm_mag2_ff;
   logic [DEN_W-1:0]   nm_den_ff;
   div_side_type       nm_side_ff;
   logic signed [35:0] negb_x, root_x, num1, num2;
   div_side_type       nm_side_in;
   // Divider output and output register.
   logic               dv_valid;
   logic [MAG_W-1:0]   dv_quo1, dv_quo2;
   div_side_type       dv_side;
   logic [MAG_W-1:0]   val1, val2;
   logic               rsp_valid_ff;
   kind_type           rsp_kind_ff;
   logic [VAL_W-1:0]   rsp_first_ff, rsp_second_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s0_a_ff    <= req_coef_a;
         s0_b_ff    <= req_coef_b;
         s0_c_ff    <= req_coef_c;
         s1_a_ff    <= s0_a_ff;
         s1_b_ff    <= s0_b_ff;
         s1_bb_ff   <= s0_b_ff * s0_b_ff;
         s1_ac_ff   <= s0_a_ff * s0_c_ff;
         s2_rad_ff  <= s2_rad_in;
         s2_side_ff <= s2_side_in;
      end
   end

   always_comb begin
      disc     = 35'(s1_bb_ff) - {s1_ac_ff[31], s1_ac_ff, 2'b00};
      a_abs    = s1_a_ff[15] ? 16'(-s1_a_ff) : s1_a_ff;
      negb_int = -{s1_b_ff[15], s1_b_ff};
      s2_side_in.a_neg   = s1_a_ff[15];
      s2_side_in.den_abs = {a_abs, 1'b0};
      s2_side_in.negb    = {negb_int, 16'b0};
      if (s1_a_ff == '0) begin
         s2_side_in.kind = KIND_NONE;
      end else if (disc > 0) begin
         s2_side_in.kind = KIND_TWO;
      end else if (disc == 0) begin
         s2_side_in.kind = KIND_DOUBLE;
      end else begin
         s2_side_in.kind = KIND_COMPLEX;
      end
      s2_rad_in = disc[34] ? RAD_W'(-disc) : disc[RAD_W-1:0];
   end

   qrs_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_valid_ff),
      .in_rad    (s2_rad_ff),
      .in_side   (s2_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_comb begin
      negb_x = 36'(sq_side.negb);
      root_x = {2'b00, sq_root};
      case (sq_side.kind)
         KIND_TWO: begin
            num1 = negb_x + root_x;
            num2 = negb_x - root_x;
         end
         KIND_COMPLEX: begin
            num1 = negb_x;
            num2 = root_x;
         end
         default: begin
            num1 = negb_x;
            num2 = negb_x;
         end
      endcase
      nm_side_in.kind = sq_side.kind;
      nm_side_in.neg1 = num1[35] ^ sq_side.a_neg;
      // The imaginary part is divided by |2a|, so only its own sign counts.
      nm_side_in.neg2 = num2[35] ^ (sq_side.a_neg && sq_side.kind != KIND_COMPLEX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_valid_ff <= 1'b0;
      end else if (advance) begin
         nm_valid_ff <= sq_valid;
      end
      if (advance) begin
         nm_mag1_ff <= num1[35] ? MAG_W'(-num1) : num1[MAG_W-1:0];
         nm_mag2_ff <= num2[35] ? MAG_W'(-num2) : num2[MAG_W-1:0];
         nm_den_ff  <= sq_side.den_abs;
         nm_side_ff <= nm_side_in;
      end
   end

   qrs_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (nm_valid_ff),
      .in_num1   (nm_mag1_ff),
      .in_num2   (nm_mag2_ff),
      .in_den    (nm_den_ff),
      .in_side   (nm_side_ff),
      .out_valid (dv_valid),
      .out_quo1  (dv_quo1),
      .out_quo2  (dv_quo2),
      .out_side  (dv_side)
   );

   always_comb begin
      val1 = dv_side.neg1 ? MAG_W'(-dv_quo1) : dv_quo1;
      val2 = dv_side.neg2 ? MAG_W'(-dv_quo2) : dv_quo2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
      if (advance) begin
         rsp_kind_ff <= dv_side.kind;
         if (dv_side.kind == KIND_NONE) begin
            rsp_first_ff  <= '0;
            rsp_second_ff <= '0;
         end else begin
            rsp_first_ff  <= val1[VAL_W-1:0];
            rsp_second_ff <= val2[VAL_W-1:0];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_root_kind    = rsp_kind_ff;
   assign rsp_first_value  = rsp_first_ff;
   assign rsp_second_value = rsp_second_ff;

   `QRS_ASSERT(a_none_zero, clock, reset, rsp_valid_ff && rsp_kind_ff == KIND_NONE |-> rsp_first_ff == '0 && rsp_second_ff == '0, "non-quadratic result not zero")
   `QRS_ASSERT(a_double_same, clock, reset, rsp_valid_ff && rsp_kind_ff == KIND_DOUBLE |-> rsp_first_ff == rsp_second_ff, "double root values differ")
   `QRS_ASSERT(a_imag_pos, clock, reset, rsp_valid_ff && rsp_kind_ff == KIND_COMPLEX |-> !rsp_second_ff[VAL_W-1], "negative imaginary part")
   `QRS_ASSERT(a_hold, clock, reset, rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_first_ff) && $stable(rsp_kind_ff), "stalled result changed")
endmodule

>>> test/quadratic_root_solver_checker.sv
// Checker for the quadratic root solver: watches both channels, predicts each result.
// Depends on qrs_pkg for the root kind codes and the value width.
module quadratic_root_solver_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [15:0]                req_coef_a,
   input  logic signed [15:0]                req_coef_b,
   input  logic signed [15:0]                req_coef_c,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [1:0]                        rsp_root_kind,
   input  logic signed [qrs_pkg::VAL_W-1:0]  rsp_first_value,
   input  logic signed [qrs_pkg::VAL_W-1:0]  rsp_second_value,
   output int                                fail_count,
   output int                                roots_pending
);
   import qrs_pkg::*;

   typedef struct {
      kind_type                 kind;
      logic signed [VAL_W-1:0]  first;
      logic signed [VAL_W-1:0]  second;
   } roots_type;

   roots_type expected_roots[$];

   assign roots_pending = expected_roots.size();

   // Floor of sqrt(d * 2^32), two radicand bits per step.
   function automatic longint unsigned root_q16(longint unsigned d);
      longint unsigned rem, root, trial, pair;
      rem = 0;
      root = 0;
      for (int i = 32; i >= 0; i--) begin
         pair = (i >= 16) ? ((d >> (2 * (i - 16))) & 64'd3) : 64'd0;
         rem = (rem << 2) | pair;
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic roots_type solve_roots(logic signed [15:0] a, logic signed [15:0] b,
                                             logic signed [15:0] c);
      roots_type r;
      longint sa, sb, sc, disc, den, negb, s, v1, v2;
      sa = a;
      sb = b;
      sc = c;
      if (sa == 0) begin
         r.kind = KIND_NONE;
         r.first = '0;
         r.second = '0;
         return r;
      end
      disc = sb * sb - 4 * sa * sc;
      den = 2 * sa;
      negb = -sb * 65536;
      if (disc > 0) begin
         s = longint'(root_q16(disc));
         v1 = (negb + s) / den;
         v2 = (negb - s) / den;
         r.kind = KIND_TWO;
      end else if (disc == 0) begin
         v1 = negb / den;
         v2 = v1;
         r.kind = KIND_DOUBLE;
      end else begin
         s = longint'(root_q16(-disc));
         v1 = negb / den;
         v2 = s / (den < 0 ? -den : den);
         r.kind = KIND_COMPLEX;
      end
      r.first = v1[VAL_W-1:0];
      r.second = v2[VAL_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      roots_type e;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_roots.push_back(solve_roots(req_coef_a, req_coef_b, req_coef_c));
         if (rsp_valid && !rsp_stall) begin
            if (expected_roots.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               e = expected_roots.pop_front();
               if (rsp_root_kind !== e.kind)
                  report_mismatch($sformatf("root_kind %0d, expected %0d",
                                            rsp_root_kind, e.kind));
               if (rsp_first_value !== e.first)
                  report_mismatch($sformatf("first_value %0d, expected %0d",
                                            rsp_first_value, e.first));
               if (rsp_second_value !== e.second)
                  report_mismatch($sformatf("second_value %0d, expected %0d",
                                            rsp_second_value, e.second));
            end
         end
      end
   end
endmodule

>>> test/quadratic_root_solver_core_tb.sv
// Top of the quadratic root solver testbench: clock, reset, stimulus and verdict.
// Depends on qrs_pkg, the solver core and quadratic_root_solver_checker.
module quadratic_root_solver_core_tb;
   import qrs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [15:0]        req_coef_a;
   logic signed [15:0]        req_coef_b;
   logic signed [15:0]        req_coef_c;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [1:0]                rsp_root_kind;
   logic signed [VAL_W-1:0]   rsp_first_value;
   logic signed [VAL_W-1:0]   rsp_second_value;
   int                        fail_count;
   int                        roots_pending;
   int                        cycle_count;
   bit                        stimulus_done;

   quadratic_root_solver_core DUT (.*);

   quadratic_root_solver_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int gap_length();
      if ($urandom_range(0, 3) != 0)
         return 0;
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
   endfunction

   function automatic logic [15:0] random_coef();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(int'($urandom_range(0, 8)) - 4);
         3: return 16'(int'($urandom_range(0, 400)) - 200);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_request(logic [15:0] a, logic [15:0] b, logic [15:0] c);
      int gap;
      gap = gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Receiver: stalls in bursts, with long quiet stretches of no stall at all.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) < 3)
            repeat ($urandom_range(50, 300)) @(negedge clock);
         hold = gap_length();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int ta, tb, tc;
      logic [15:0] a, b;
      reset = 1'b1;
      req_valid = 1'b0;
      req_coef_a = '0;
      req_coef_b = '0;
      req_coef_c = '0;
      stimulus_done = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed: zero a, extremes, double roots, negative a with a complex pair.
      send_request(16'sd0, 16'sd5, 16'sd7);
      send_request(16'sd0, 16'h8000, 16'h7fff);
      send_request(16'sd1, 16'sd0, 16'sd0);
      send_request(16'sd1, -16'sd2, 16'sd1);
      send_request(16'sd1, 16'sd4, 16'sd4);
      send_request(16'sd1, 16'sd0, -16'sd1);
      send_request(16'sd1, 16'sd3, 16'sd2);
      send_request(16'sd1, 16'sd0, 16'sd1);
      send_request(-16'sd1, 16'sd0, -16'sd1);
      send_request(-16'sd3, 16'sd1, -16'sd5);
      send_request(16'h8000, 16'h8000, 16'h7fff);
      send_request(16'h8000, 16'h8000, 16'h8000);
      send_request(16'h7fff, 16'h7fff, 16'h7fff);
      send_request(16'h7fff, 16'h8000, 16'h8000);
      send_request(16'h8000, 16'h7fff, 16'h7fff);
      send_request(16'sd1, 16'h8000, 16'h8000);
      send_request(16'sd1, 16'h7fff, 16'h7fff);
      send_request(16'h8000, 16'sd0, 16'sd0);
      send_request(16'hffff, 16'hffff, 16'hffff);
      send_request(16'sd3, 16'sd5, 16'sd7);
      send_request(-16'sd7, 16'sd2, 16'sd3);
      for (int i = 0; i < 1030; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            // Perfect square trinomial, so the discriminant is exactly zero.
            ta = $urandom_range(0, 200) - 100;
            tb = $urandom_range(0, 200) - 100;
            if (ta == 0)
               ta = 1;
            tc = $urandom_range(0, 1) ? 1 : -1;
            send_request(16'(tc * ta * ta), 16'(tc * 2 * ta * tb), 16'(tc * tb * tb));
         end else begin
            a = random_coef();
            b = random_coef();
            send_request(a, b, random_coef());
         end
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      wait (stimulus_done);
      while (roots_pending != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
